@@ src/i2ew_pkg.sv @@
// ----------------------------------------------------------------------------
// i2ew_pkg
// Shared widths, digit type and word-token codes for the number speller.
// ----------------------------------------------------------------------------
package i2ew_pkg;

  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);

  typedef logic [3:0]        digit_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam code_t TOK_ZERO     = 5'd0;
  localparam code_t TOK_TEN      = 5'd10;
  localparam code_t TOK_TENS_OFS = 5'd18;
  localparam code_t TOK_HUNDRED  = 5'd28;
  localparam code_t TOK_THOUSAND = 5'd29;
  localparam code_t TOK_MILLION  = 5'd30;
  localparam code_t TOK_BILLION  = 5'd31;

endpackage

@@ src/i2ew_bcd.sv @@
// ----------------------------------------------------------------------------
// i2ew_bcd
// Shift-and-add-3 binary to decimal converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module i2ew_bcd import i2ew_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               done_o,
  output logic [BCD_W-1:0]   bcd_o
);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   adj;
  logic               done_q;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ src/i2ew_words.sv @@
// ----------------------------------------------------------------------------
// i2ew_words
// Walks the digit groups and emits word tokens with one-token lookahead.
// ----------------------------------------------------------------------------
module i2ew_words import i2ew_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BCD_W-1:0] bcd_i,
  output logic             done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output code_t            word_code_o,
  output logic             last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_HDIG, ST_HWORD, ST_REST, ST_ONES, ST_SCALE, ST_FLUSH
  } state_e;

  state_e     state_q;
  logic [1:0] grp_q;
  logic       pend_v_q;
  code_t      pend_code_q;
  logic       out_v_q;
  code_t      out_code_q;
  logic       out_last_q;
  logic       done_q;

  digit_t h, t, o;
  logic   emit;
  code_t  code;
  logic   out_free;
  logic   advance;
  logic   out_load;
  logic   grp_nz;

  // digits of the current group, billion group first
  always_comb begin
    case (grp_q)
      2'd0: begin
        h = '0; t = '0; o = bcd_i[39:36];
      end
      2'd1: begin
        h = bcd_i[35:32]; t = bcd_i[31:28]; o = bcd_i[27:24];
      end
      2'd2: begin
        h = bcd_i[23:20]; t = bcd_i[19:16]; o = bcd_i[15:12];
      end
      default: begin
        h = bcd_i[11:8]; t = bcd_i[7:4]; o = bcd_i[3:0];
      end
    endcase
  end

  assign grp_nz = (h != '0) || (t != '0) || (o != '0);

  always_comb begin
    emit = 1'b0;
    code = TOK_ZERO;
    case (state_q)
      ST_HDIG: begin
        emit = (h != '0);
        code = {1'b0, h};
      end
      ST_HWORD: begin
        emit = (h != '0);
        code = TOK_HUNDRED;
      end
      ST_REST: begin
        emit = (t != '0) || (o != '0);
        if (t >= 4'd2) begin
          code = TOK_TENS_OFS + {1'b0, t};
        end else if (t[0]) begin
          code = TOK_TEN + {1'b0, o};
        end else begin
          code = {1'b0, o};
        end
      end
      ST_ONES: begin
        emit = (t >= 4'd2) && (o != '0);
        code = {1'b0, o};
      end
      ST_SCALE: begin
        emit = grp_nz && (grp_q != 2'd3);
        case (grp_q)
          2'd0:    code = TOK_BILLION;
          2'd1:    code = TOK_MILLION;
          default: code = TOK_THOUSAND;
        endcase
      end
      default: begin
        emit = 1'b0;
        code = TOK_ZERO;
      end
    endcase
  end

  assign out_free = !out_v_q || out_ready_i;
  // a token only waits when the lookahead slot and output are both full
  assign advance  = !emit || !pend_v_q || out_free;
  // output register takes the lookahead token
  assign out_load = (state_q == ST_FLUSH) ? out_free :
                    ((state_q != ST_IDLE) && advance && emit && pend_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      grp_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      done_q     <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_FLUSH) && out_free;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            grp_q <= '0;
            if (bcd_i == '0) begin
              pend_v_q    <= 1'b1;
              pend_code_q <= TOK_ZERO;
              state_q     <= ST_FLUSH;
            end else begin
              state_q <= ST_HDIG;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_code_q <= pend_code_q;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          if (advance) begin
            if (emit) begin
              if (pend_v_q) begin
                out_code_q <= pend_code_q;
                out_last_q <= 1'b0;
              end
              pend_v_q    <= 1'b1;
              pend_code_q <= code;
            end
            case (state_q)
              ST_HDIG:  state_q <= ST_HWORD;
              ST_HWORD: state_q <= ST_REST;
              ST_REST:  state_q <= ST_ONES;
              ST_ONES:  state_q <= ST_SCALE;
              default: begin
                if (grp_q == 2'd3) begin
                  state_q <= ST_FLUSH;
                end else begin
                  grp_q   <= grp_q + 2'd1;
                  state_q <= ST_HDIG;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign out_valid_o = out_v_q;
  assign word_code_o = out_code_q;
  assign last_word_o = out_last_q;

endmodule

@@ src/integer_to_english_word_tokens_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_top
// Spells a 31-bit unsigned integer as a run of English word-token codes.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one request, value_i.
//   out channel : out_valid_o / out_ready_i carry one word token per beat,
//                 word_code_o, with last_word_o set on the final word.
//   A request gives 1 to 16 tokens. in_ready_o is high only when idle.
//   Timing: the shift-and-add-3 conversion starts in the cycle after
//   acceptance (one value bit per cycle in the digit adjust unit). The
//   sequencer then spends a start step; hundreds-digit, hundred-word,
//   rest, ones and scale steps on each of the four digit groups; and
//   a flush step. Zero skips the group walk. in_ready_o rises in the
//   cycle after the last token becomes valid.
//   The last token is held in the output register, and the next request
//   is accepted while it waits.
//   A stalled receiver freezes the sequencer once the output register and
//   its one-token lookahead slot are full; no token is dropped.
//   Reset clears all control state and leaves the output channel empty.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_top import i2ew_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CODE_W-1:0]  word_code_o,
  output logic               last_word_o
);

  typedef enum logic [1:0] {
    TS_IDLE, TS_CONV, TS_WORDS
  } top_state_e;

  top_state_e       state_q;
  logic             in_acc;
  logic             conv_done;
  logic             words_done;
  logic [BCD_W-1:0] bcd;

  assign in_ready_o = (state_q == TS_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
    end else begin
      case (state_q)
        TS_IDLE: begin
          if (in_acc) state_q <= TS_CONV;
        end
        TS_CONV: begin
          if (conv_done) state_q <= TS_WORDS;
        end
        TS_WORDS: begin
          if (words_done) state_q <= TS_IDLE;
        end
        default: state_q <= TS_IDLE;
      endcase
    end
  end

  i2ew_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (value_i),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  i2ew_words u_words (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (conv_done),
    .bcd_i       (bcd),
    .done_o      (words_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_code_o (word_code_o),
    .last_word_o (last_word_o)
  );

endmodule

@@ src/i2ew_chk.sv @@
// ----------------------------------------------------------------------------
// i2ew_chk
// Port-level checks for the number speller, bound to the top level.
// ----------------------------------------------------------------------------
module i2ew_chk import i2ew_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [VALUE_W-1:0] value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CODE_W-1:0]  word_code_o,
  input logic               last_word_o
);

  // a waiting request keeps its value
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("request changed while waiting");

  // a held word must not change under backpressure
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(word_code_o) && $stable(last_word_o))
    else $error("output word changed while stalled");

  // busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // zero is only ever spoken alone
  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (word_code_o == TOK_ZERO) |-> last_word_o)
    else $error("zero token not marked last");

  // while a non-final word is out, the block is still on that number
  a_no_req_mid_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> !in_ready_o)
    else $error("ready high in the middle of a number");

endmodule

bind integer_to_english_word_tokens_top i2ew_chk u_i2ew_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .word_code_o (word_code_o),
  .last_word_o (last_word_o)
);

@@ verif/i2ew_word_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ew_word_checker
// Watches both channels of the number speller, predicts the word tokens of
// every accepted request and compares each token beat against them in order.
// ----------------------------------------------------------------------------
module i2ew_word_checker import i2ew_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CODE_W-1:0]  word_code_i,
  input  logic               last_word_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        words_pending_o
);

  typedef struct packed {
    code_t code;
    logic  last;
  } word_tok_t;

  word_tok_t   expected_words[$];
  code_t       spelled[$];
  int unsigned mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  // one group of three digits, then its scale word
  function automatic void spell_group(input int unsigned grp, input bit scaled,
                                      input code_t scale_tok);
    int unsigned hundreds;
    int unsigned rest;
    hundreds = grp / 100;
    rest     = grp % 100;
    if (grp == 0) return;
    if (hundreds != 0) begin
      spelled.push_back(code_t'(hundreds));
      spelled.push_back(TOK_HUNDRED);
    end
    if (rest != 0) begin
      if (rest < 20) begin
        spelled.push_back(code_t'(rest));
      end else begin
        spelled.push_back(TOK_TENS_OFS + code_t'(rest / 10));
        if (rest % 10 != 0) spelled.push_back(code_t'(rest % 10));
      end
    end
    if (scaled) spelled.push_back(scale_tok);
  endfunction

  function automatic void spell_value(input logic [VALUE_W-1:0] v);
    int unsigned n;
    n = v;
    spelled.delete();
    if (n == 0) begin
      spelled.push_back(TOK_ZERO);
    end else begin
      spell_group(n / 1000000000, 1'b1, TOK_BILLION);
      spell_group((n / 1000000) % 1000, 1'b1, TOK_MILLION);
      spell_group((n / 1000) % 1000, 1'b1, TOK_THOUSAND);
      spell_group(n % 1000, 1'b0, TOK_ZERO);
    end
    foreach (spelled[k])
      expected_words.push_back('{code: spelled[k], last: (k == spelled.size() - 1)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_tok_t exp_tok;
    if (!rst_ni) begin
      expected_words.delete();
    end else begin
      if (in_valid_i && in_ready_i) spell_value(value_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("word token with nothing expected: word_code %0d, last_word %0d",
                 word_code_i, last_word_i);
          mismatch_cnt++;
        end else begin
          exp_tok = expected_words.pop_front();
          if (word_code_i !== exp_tok.code) begin
            $error("word_code mismatch: expected %0d, actual %0d", exp_tok.code,
                   word_code_i);
            mismatch_cnt++;
          end
          if (last_word_i !== exp_tok.last) begin
            $error("last_word mismatch: expected %0d, actual %0d", exp_tok.last,
                   last_word_i);
            mismatch_cnt++;
          end
        end
      end
    end
    words_pending_o <= expected_words.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives numbers into the speller with random gaps and output stalls, one
// long output hold-off and a drain pause; the checker judges the tokens.
// ----------------------------------------------------------------------------
module tb_top;
  import i2ew_pkg::*;

  localparam int unsigned NUM_RANDOM  = 184;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_VALUE   = 32'h7fff_ffff;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CODE_W-1:0]  word_code_o;
  logic               last_word_o;

  int unsigned mismatch_cnt;
  int unsigned words_pending;
  int unsigned cycle_cnt   = 0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  bit          send_gaps_on  = 1'b1;

  integer_to_english_word_tokens_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_code_o (word_code_o),
    .last_word_o (last_word_o)
  );

  i2ew_word_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_code_i     (word_code_o),
    .last_word_i     (last_word_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .words_pending_o (words_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // three-digit group biased toward teens, round tens and zero
  function automatic int unsigned pick_group();
    int unsigned rest;
    case ($urandom_range(0, 5))
      0:       rest = 0;
      1:       rest = $urandom_range(1, 19);
      2:       rest = 10 * $urandom_range(2, 9);
      default: rest = $urandom_range(0, 99);
    endcase
    if ($urandom_range(0, 3) == 0) return 0;
    return 100 * $urandom_range(0, 9) + rest;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    longint unsigned v;
    case ($urandom_range(0, 9))
      0, 1: return VALUE_W'($urandom());
      2:    return VALUE_W'($urandom_range(0, 999));
      3:    return VALUE_W'($urandom_range(0, 999999));
      default: begin
        v = longint'($urandom_range(0, 2)) * 1000000000 + longint'(pick_group()) * 1000000
          + longint'(pick_group()) * 1000 + longint'(pick_group());
        if (v > MAX_VALUE) v -= 1000000000;
        return VALUE_W'(v);
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance or after the random gap that follows it
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int unsigned gap;
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    gap = send_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= VALUE_W'($urandom());
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // output side
  initial begin : receiver
    int unsigned stall_left;
    int unsigned seg_left;
    bit          ready_gaps_on;
    stall_left    = 0;
    seg_left      = 100;
    ready_gaps_on = 1'b1;
    out_ready_i   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_off_req && !hold_off_done) begin
        // long hold-off so the block backs up into its input
        out_ready_i   <= 1'b0;
        stall_left    = HOLD_CYCLES - 1;
        hold_off_done = 1'b1;
      end else if (!ready_gaps_on) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left  = idle_len();
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      seg_left--;
      if (seg_left == 0) begin
        ready_gaps_on = ($urandom_range(0, 2) != 0);
        seg_left      = $urandom_range(30, 200);
      end
    end
  end

  initial begin : stimulus
    int unsigned directed[$];
    directed = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001,
                 1010, 100000, 1000000, 1000001, 999999999, 1000000000, 2000000000,
                 1002003004, 1234567890, 2147483646, 2147483647};
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[k]) send_value(VALUE_W'(directed[k]));
    drain_words();

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      if (n == 40) hold_off_req = 1'b1;
      if (n == 120) drain_words();
      if (n % 35 == 0) send_gaps_on = ($urandom_range(0, 2) != 0);
      send_value(pick_value());
    end
    drain_words();
    repeat (100) @(negedge clk_i);

    if (mismatch_cnt == 0 && words_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
